@@ src/ncst_pkg.sv @@
// ----------------------------------------------------------------------------
// ncst_pkg
// Shared types, token codes and the reading builder for the number reader.
// ----------------------------------------------------------------------------
package ncst_pkg;

    localparam int NUM_W      = 14;
    localparam int TOK_W      = 4;
    localparam int MAX_TOKS   = 7;
    localparam int CNT_W      = 3;
    localparam int QDEPTH_DEF = 4;
    localparam int NUM_MAX    = 9999;

    localparam logic [TOK_W-1:0] TOK_ZERO     = 4'd0;
    localparam logic [TOK_W-1:0] TOK_ONE      = 4'd1;
    localparam logic [TOK_W-1:0] TOK_TEN      = 4'd10;
    localparam logic [TOK_W-1:0] TOK_HUNDRED  = 4'd11;
    localparam logic [TOK_W-1:0] TOK_THOUSAND = 4'd12;

    typedef struct packed {
        logic [MAX_TOKS-1:0][TOK_W-1:0] tok;
        logic [CNT_W-1:0]               cnt;
    } t_reading;

    // low four bits of ten times x
    function automatic logic [3:0] times10_lo(input logic [3:0] x);
        times10_lo = {x[0], 3'b000} + {x[2:0], 1'b0};
    endfunction

    function automatic t_reading build_reading(input logic [3:0] d3, input logic [3:0] d2,
                                               input logic [3:0] d1, input logic [3:0] d0);
        t_reading r;
        logic [CNT_W-1:0] k;
        r = '0;
        k = '0;
        if (d3 != TOK_ZERO) begin
            r.tok[k] = d3;           k = k + 1'b1;
            r.tok[k] = TOK_THOUSAND; k = k + 1'b1;
        end
        if (d2 != TOK_ZERO) begin
            r.tok[k] = d2;          k = k + 1'b1;
            r.tok[k] = TOK_HUNDRED; k = k + 1'b1;
            if (d1 == TOK_ZERO && d0 != TOK_ZERO) begin
                r.tok[k] = TOK_ZERO; k = k + 1'b1;
                r.tok[k] = d0;       k = k + 1'b1;
            end else if (d1 != TOK_ZERO) begin
                r.tok[k] = d1;      k = k + 1'b1;
                r.tok[k] = TOK_TEN; k = k + 1'b1;
                if (d0 != TOK_ZERO) begin
                    r.tok[k] = d0; k = k + 1'b1;
                end
            end
        end else if (d3 != TOK_ZERO) begin
            if (d1 != TOK_ZERO || d0 != TOK_ZERO) begin
                r.tok[k] = TOK_ZERO; k = k + 1'b1;
                if (d1 == TOK_ZERO) begin
                    r.tok[k] = d0; k = k + 1'b1;
                end else begin
                    r.tok[k] = d1;      k = k + 1'b1;
                    r.tok[k] = TOK_TEN; k = k + 1'b1;
                    if (d0 != TOK_ZERO) begin
                        r.tok[k] = d0; k = k + 1'b1;
                    end
                end
            end
        end else if (d1 != TOK_ZERO) begin
            if (d1 != TOK_ONE) begin
                r.tok[k] = d1; k = k + 1'b1;
            end
            r.tok[k] = TOK_TEN; k = k + 1'b1;
            if (d0 != TOK_ZERO) begin
                r.tok[k] = d0; k = k + 1'b1;
            end
        end else begin
            r.tok[k] = d0; k = k + 1'b1;
        end
        r.cnt = k;
        build_reading = r;
    endfunction

endpackage

@@ src/number_to_chinese_speech_tokens.sv @@
// ----------------------------------------------------------------------------
// number_to_chinese_speech_tokens
// Reads a number 0..9999 as a sequence of spoken Chinese number tokens.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------
//   input    | push / full      | i_number[13:0]
//   result   | empty / pop      | o_token[3:0], o_last
//
// One number yields 1 to 7 tokens; the back walker drives one token per cycle
// while its output register is empty or being popped.
// The front accepts one item per cycle until the token-list queue fills;
// each number passes the front register, the queue and the walker's item register.
// Synchronous active-low reset empties the pipeline and queue.
// Numbers above 9999 are dropped and give no tokens.
// ----------------------------------------------------------------------------
module number_to_chinese_speech_tokens
    import ncst_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [NUM_W-1:0] i_number,
    output logic             empty,
    input  logic             pop,
    output logic [TOK_W-1:0] o_token,
    output logic             o_last
);

    logic     w_fq_push;
    t_reading w_fq_data;
    logic     w_fq_full;
    t_reading w_qb_data;
    logic     w_qb_empty;
    logic     w_qb_pop;

    ncst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_number (i_number),
        .o_full   (full),
        .o_q_push (w_fq_push),
        .o_q_data (w_fq_data),
        .i_q_full (w_fq_full)
    );

    ncst_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .i_data  (w_fq_data),
        .o_full  (w_fq_full),
        .i_pop   (w_qb_pop),
        .o_data  (w_qb_data),
        .o_empty (w_qb_empty)
    );

    ncst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (w_qb_data),
        .i_q_empty (w_qb_empty),
        .o_q_pop   (w_qb_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_token   (o_token),
        .o_last    (o_last)
    );

endmodule

@@ src/ncst_front.sv @@
// ----------------------------------------------------------------------------
// ncst_front
// Accept a number, split it into decimal digits and build its token list.
// ----------------------------------------------------------------------------
module ncst_front
    import ncst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [NUM_W-1:0] i_number,
    output logic             o_full,
    output logic             o_q_push,
    output t_reading         o_q_data,
    input  logic             i_q_full
);

    logic        r_va;
    logic        r_inr;
    logic [3:0]  r_q1000;
    logic [3:0]  r_q100_lo;
    logic [3:0]  r_q10_lo;
    logic [3:0]  r_n_lo;

    logic [27:0] w_p1000;
    logic [26:0] w_p100;
    logic [29:0] w_p10;
    logic        w_stall;
    logic [3:0]  w_d2;
    logic [3:0]  w_d1;
    logic [3:0]  w_d0;

    // quotients by reciprocal multiply, exact over 0..9999
    assign w_p1000 = {14'd0, i_number} * 28'd8389;
    assign w_p100  = {13'd0, i_number} * 27'd5243;
    assign w_p10   = {16'd0, i_number} * 30'd52429;

    assign w_stall = r_va && r_inr && i_q_full;
    assign o_full  = w_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (!w_stall) begin
            r_va <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_inr     <= (i_number <= NUM_W'(NUM_MAX));
            r_q1000   <= w_p1000[26:23];
            r_q100_lo <= w_p100[22:19];
            r_q10_lo  <= w_p10[22:19];
            r_n_lo    <= i_number[3:0];
        end
    end

    assign w_d2 = r_q100_lo - times10_lo(r_q1000);
    assign w_d1 = r_q10_lo - times10_lo(r_q100_lo);
    assign w_d0 = r_n_lo - times10_lo(r_q10_lo);

    assign o_q_push = r_va && r_inr && !i_q_full;
    assign o_q_data = build_reading(r_q1000, w_d2, w_d1, w_d0);

    a_digits_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_va && r_inr) |-> (w_d2 <= 4'd9 && w_d1 <= 4'd9 && w_d0 <= 4'd9))
        else $error("digit out of range");

    a_cnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (o_q_data.cnt != '0))
        else $error("empty reading pushed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> (r_va && $stable(r_q10_lo) && $stable(r_n_lo)))
        else $error("front stage lost item");

endmodule

@@ src/ncst_queue.sv @@
// ----------------------------------------------------------------------------
// ncst_queue
// Short queue of token lists between the front and back parts.
// ----------------------------------------------------------------------------
module ncst_queue
    import ncst_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_reading i_data,
    output logic     o_full,
    input  logic     i_pop,
    output t_reading o_data,
    output logic     o_empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    t_reading            r_mem [QDEPTH];
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]    n_wp;
    logic [PTR_W-1:0]    n_rp;
    logic                w_wr;
    logic                w_rd;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp = (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= n_wp;
            end
            if (w_rd) begin
                r_rp <= n_rp;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count overflow");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

@@ src/ncst_back.sv @@
// ----------------------------------------------------------------------------
// ncst_back
// Walk one token list and drive one token per cycle into the output register while it is empty or being popped.
// ----------------------------------------------------------------------------
module ncst_back
    import ncst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_reading         i_q_data,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [TOK_W-1:0] o_token,
    output logic             o_last
);

    logic             r_busy;
    t_reading         r_item;
    logic [CNT_W-1:0] r_idx;
    logic             r_ov;
    logic [TOK_W-1:0] r_otok;
    logic             r_olast;

    logic             w_out_can;
    logic             w_emit;
    logic             w_is_last;
    logic             w_load;

    assign w_out_can = !r_ov || i_pop;
    assign w_emit    = r_busy && w_out_can;
    assign w_is_last = (r_idx == r_item.cnt - 1'b1);
    assign w_load    = !i_q_empty && (!r_busy || (w_emit && w_is_last));
    assign o_q_pop   = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_emit) begin
                r_busy <= !w_is_last;
                r_idx  <= r_idx + 1'b1;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_q_data;
        end
        if (w_emit) begin
            r_otok  <= r_item.tok[r_idx];
            r_olast <= w_is_last;
        end
    end

    assign o_empty = !r_ov;
    assign o_token = r_otok;
    assign o_last  = r_olast;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_item.cnt))
        else $error("token index past end of list");

    a_tok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_otok <= TOK_THOUSAND))
        else $error("bad token code");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_is_last && !w_load) |=> !r_busy)
        else $error("walker kept running after last token");

endmodule

@@ test/ncst_reading_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ncst_reading_checker
// Watches both queue channels of the number reader. It builds the expected
// token reading of each accepted number and compares every popped token and
// last flag against the oldest expected token, in order.
// ----------------------------------------------------------------------------
module ncst_reading_checker
    import ncst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  logic [NUM_W-1:0] i_number,
    input  logic             i_empty,
    input  logic             i_pop,
    input  logic [TOK_W-1:0] i_token,
    input  logic             i_last,
    output int               o_errors,
    output int               o_pending,
    output int               o_tokens
);

    typedef struct packed {
        logic [TOK_W-1:0] token;
        logic             last;
    } t_spoken;

    t_spoken          spoken_q[$];
    logic [TOK_W-1:0] word_q[$];
    int               errors = 0;
    int               tokens = 0;

    function automatic void say_tens(input logic [TOK_W-1:0] tens,
                                     input logic [TOK_W-1:0] units);
        word_q.push_back(tens);
        word_q.push_back(TOK_TEN);
        if (units != TOK_ZERO) begin
            word_q.push_back(units);
        end
    endfunction

    function automatic void spell_number(input logic [NUM_W-1:0] n);
        int               v;
        logic [TOK_W-1:0] th;
        logic [TOK_W-1:0] hu;
        logic [TOK_W-1:0] te;
        logic [TOK_W-1:0] un;
        v = int'(n);
        if (v > NUM_MAX) begin
            return;
        end
        th = TOK_W'(v / 1000);
        hu = TOK_W'((v / 100) % 10);
        te = TOK_W'((v / 10) % 10);
        un = TOK_W'(v % 10);
        word_q.delete();
        if (v >= 1000) begin
            word_q.push_back(th);
            word_q.push_back(TOK_THOUSAND);
        end
        if (hu != TOK_ZERO) begin
            word_q.push_back(hu);
            word_q.push_back(TOK_HUNDRED);
            if (te != TOK_ZERO) begin
                say_tens(te, un);
            end else if (un != TOK_ZERO) begin
                word_q.push_back(TOK_ZERO);
                word_q.push_back(un);
            end
        end else if (v >= 1000) begin
            if (te != TOK_ZERO) begin
                word_q.push_back(TOK_ZERO);
                say_tens(te, un);
            end else if (un != TOK_ZERO) begin
                word_q.push_back(TOK_ZERO);
                word_q.push_back(un);
            end
        end else if (v >= 10) begin
            // drop the leading one from 10..19
            if (te != TOK_ONE) begin
                word_q.push_back(te);
            end
            word_q.push_back(TOK_TEN);
            if (un != TOK_ZERO) begin
                word_q.push_back(un);
            end
        end else begin
            word_q.push_back(un);
        end
        for (int i = 0; i < word_q.size(); i++) begin
            spoken_q.push_back(t_spoken'{word_q[i], i == word_q.size() - 1});
        end
    endfunction

    always @(posedge i_clk) begin
        t_spoken want;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                tokens++;
                if (spoken_q.size() == 0) begin
                    $error("token %0d last %0d with no reading pending", i_token, i_last);
                    errors++;
                end else begin
                    want = spoken_q.pop_front();
                    if (i_token !== want.token) begin
                        $error("token: expected %0d, actual %0d", want.token, i_token);
                        errors++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        errors++;
                    end
                end
            end
            if (i_push && !i_full) begin
                spell_number(i_number);
            end
        end
        o_pending <= spoken_q.size();
        o_errors  <= errors;
        o_tokens  <= tokens;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives numbers into the Chinese number reader in bursts, pops tokens under
// several stall patterns, fills the block during a long pop hold-off and
// drains it between phases. The checker compares every token.
// ----------------------------------------------------------------------------
module tb;
    import ncst_pkg::*;

    localparam int NUM_TARGET = 370;
    localparam int LIMIT      = 200000;
    localparam int DRAIN_WAIT = 20;
    localparam int HOLD_LEN   = 150;

    typedef enum int {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_PERIODIC
    } t_pop_mode;

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             push     = 1'b0;
    logic             pop      = 1'b0;
    logic [NUM_W-1:0] i_number = '0;
    logic             full;
    logic             empty;
    logic [TOK_W-1:0] o_token;
    logic             o_last;

    int        errors;
    int        pending;
    int        tokens;
    int        cycles    = 0;
    int        in_range  = 0;
    int        out_range = 0;
    int        pop_tick  = 0;
    int        hold_left = 0;
    bit        hold_req  = 1'b0;
    t_pop_mode pop_mode  = POP_HALF;

    always #5 i_clk = ~i_clk;

    number_to_chinese_speech_tokens u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_number (i_number),
        .empty    (empty),
        .pop      (pop),
        .o_token  (o_token),
        .o_last   (o_last)
    );

    ncst_reading_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_number  (i_number),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_token   (o_token),
        .i_last    (o_last),
        .o_errors  (errors),
        .o_pending (pending),
        .o_tokens  (tokens)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens pending", cycles, pending);
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        pop_tick++;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (pop_mode)
                POP_ALWAYS: pop <= 1'b1;
                POP_HALF:   pop <= 1'($urandom_range(0, 1));
                POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default:    pop <= (pop_tick % 7) < 4;
            endcase
        end
    end

    task automatic offer_number(input logic [NUM_W-1:0] n);
        push <= 1'b1;
        i_number <= n;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (int'(n) <= NUM_MAX) begin
            in_range++;
        end else begin
            out_range++;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [NUM_W-1:0] pick_number();
        int pick;
        int v = 0;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            return NUM_W'($urandom_range(NUM_MAX + 1, (1 << NUM_W) - 1));
        end
        if (pick < 4) begin
            return NUM_W'($urandom_range(0, 99));
        end
        if (pick < 5) begin
            return NUM_W'($urandom_range(0, NUM_MAX));
        end
        // favor zeros in every digit position
        for (int i = 0; i < 4; i++) begin
            v = v * 10 + (($urandom_range(0, 4) < 2) ? 0 : int'($urandom_range(1, 9)));
        end
        return NUM_W'(v);
    endfunction

    initial begin
        int directed [25] = '{0, 1, 9, 10, 11, 19, 20, 99, 100, 101, 110, 111, 119, 120,
                              1000, 1001, 1010, 1011, 1100, 1234, 7080, 9009, 9999,
                              10000, 16383};
        int phase = 0;
        int gap;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            offer_number(NUM_W'(directed[i]));
        end
        wait_drained();

        // hold pop and keep offering so the block fills and stalls its input
        hold_req = 1'b1;
        repeat (20) offer_number(pick_number());
        wait_drained();

        while (in_range + out_range < NUM_TARGET) begin
            pop_mode = t_pop_mode'(phase % 4);
            repeat (6) begin
                repeat ($urandom_range(1, 12)) offer_number(pick_number());
                gap = (phase % 4 == 0) ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            wait_drained();
            phase++;
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("read %0d numbers in range and offered %0d above range over %0d phases",
                 in_range, out_range, phase);
        $display("checked %0d tokens in %0d cycles", tokens, cycles);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
